// ===== rtl/ikpfb_pkg.sv =====
package ikpfb_pkg;

	localparam int COORD_W = 32;
	localparam int UNIT_W = 32;
	localparam int UNIT_FRAC_BITS = 30;
	localparam int NORM_BITS = 31;
	localparam int ROOT_BITS = 32;
	localparam int SQ_W = 2 * ROOT_BITS;
	localparam int SQRT_STEPS_PER_STAGE = 2;
	localparam int DIV_STEPS_PER_STAGE = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] root_x;
		logic signed [COORD_W-1:0] root_y;
		logic signed [COORD_W-1:0] root_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
		logic signed [COORD_W-1:0] up_x;
		logic signed [COORD_W-1:0] up_y;
		logic signed [COORD_W-1:0] up_z;
	} points_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] xaxis_x;
		logic signed [UNIT_W-1:0] xaxis_y;
		logic signed [UNIT_W-1:0] xaxis_z;
		logic signed [UNIT_W-1:0] yaxis_x;
		logic signed [UNIT_W-1:0] yaxis_y;
		logic signed [UNIT_W-1:0] yaxis_z;
		logic signed [UNIT_W-1:0] zaxis_x;
		logic signed [UNIT_W-1:0] zaxis_y;
		logic signed [UNIT_W-1:0] zaxis_z;
		logic signed [COORD_W-1:0] mid_x;
		logic signed [COORD_W-1:0] mid_y;
		logic signed [COORD_W-1:0] mid_z;
	} frame_t;

endpackage

// ===== rtl/ik_plane_frame_builder.sv =====
// Builds an orthonormal frame from a root, an end and an up-vector target point
// (signed Q16.16): the root/end midpoint plus unit X, Y and Z axes in signed
// Q2.30. A new request is taken every cycle while the output is not stalled.
// The path runs through three normalizers in series, each with a 16-stage
// square root and a restoring divider that retires two quotient bits per stage,
// plus one multiplier stage ahead of each cross product. The whole pipeline
// holds while a finished frame is stalled at the output.
module ik_plane_frame_builder #(
	parameter int UNIT_FRAC_BITS = ikpfb_pkg::UNIT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic point_valid,
	output logic point_stall,
	input  ikpfb_pkg::points_t points,
	output logic frame_valid,
	input  logic frame_stall,
	output ikpfb_pkg::frame_t frame
);

	localparam int CWD = ikpfb_pkg::COORD_W;
	localparam int DFW = CWD + 1;
	localparam int UW = ikpfb_pkg::UNIT_W;
	localparam int PW = 2 * UW;
	localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;

	logic en;
	logic [2:0][DFW-1:0] re_c, ru_c, sum_c;
	logic [2:0][CWD-1:0] root_c, end_c, up_c, mid_c;

	logic nre_valid, nru_valid, nx_valid, nz_valid;
	logic [2:0][UW-1:0] ure, uru, ax, az;
	logic [2*CWD-1:0] nre_side;
	logic [CWD-1:0] nru_side;
	logic [6*UW-1:0] nx_side;
	logic [9*UW-1:0] nz_side;

	logic x1_vld_s1, x2_vld_s1;
	logic signed [5:0][PW-1:0] x1_p_s1, x2_p_s1;
	logic [2:0][UW-1:0] ay_s1, x2_ay_s1, x2_ax_s1, ay_n;
	logic [2:0][CWD-1:0] mid_s1, x2_mid_s1;
	logic [2:0][PW-1:0] c1_c, c2_c;

	assign en = !(frame_valid && frame_stall);
	assign point_stall = !en;

	// differences and midpoint, exact in 33 bits
	always_comb begin
		root_c = {points.root_x, points.root_y, points.root_z};
		end_c = {points.end_x, points.end_y, points.end_z};
		up_c = {points.up_x, points.up_y, points.up_z};
		for (int c = 0; c < 3; c++) begin
			re_c[c] = {end_c[c][CWD-1], end_c[c]} - {root_c[c][CWD-1], root_c[c]};
			ru_c[c] = {up_c[c][CWD-1], up_c[c]} - {root_c[c][CWD-1], root_c[c]};
			sum_c[c] = {end_c[c][CWD-1], end_c[c]} + {root_c[c][CWD-1], root_c[c]};
			mid_c[c] = sum_c[c][DFW-1:1];
		end
	end

	// packed index 2 is x, so vectors read {x, y, z} from the top
	ikpfb_norm #(.IW(DFW), .SW(2 * CWD), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_re (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(point_valid && en),
		.in_vec(re_c),
		.in_side({mid_c[2], mid_c[1]}),
		.out_valid(nre_valid),
		.out_vec(ure),
		.out_side(nre_side)
	);

	ikpfb_norm #(.IW(DFW), .SW(CWD), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_ru (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(point_valid && en),
		.in_vec(ru_c),
		.in_side(mid_c[0]),
		.out_valid(nru_valid),
		.out_vec(uru),
		.out_side(nru_side)
	);

	// first cross product: uru x ure, with x at index 2, y at 1, z at 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_vld_s1 <= 1'b0;
		end else if (en) begin
			x1_vld_s1 <= nre_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_p_s1[0] <= PW'($signed(uru[1])) * PW'($signed(ure[0]));
			x1_p_s1[1] <= PW'($signed(uru[0])) * PW'($signed(ure[1]));
			x1_p_s1[2] <= PW'($signed(uru[0])) * PW'($signed(ure[2]));
			x1_p_s1[3] <= PW'($signed(uru[2])) * PW'($signed(ure[0]));
			x1_p_s1[4] <= PW'($signed(uru[2])) * PW'($signed(ure[1]));
			x1_p_s1[5] <= PW'($signed(uru[1])) * PW'($signed(ure[2]));
			for (int c = 0; c < 3; c++) begin
				ay_s1[c] <= UW'(-ure[c]);
			end
			mid_s1[2] <= nre_side[2*CWD-1:CWD];
			mid_s1[1] <= nre_side[CWD-1:0];
			mid_s1[0] <= nru_side;
		end
	end

	always_comb begin
		c1_c[2] = x1_p_s1[0] - x1_p_s1[1];
		c1_c[1] = x1_p_s1[2] - x1_p_s1[3];
		c1_c[0] = x1_p_s1[4] - x1_p_s1[5];
	end

	ikpfb_norm #(.IW(PW), .SW(6 * UW), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(x1_vld_s1),
		.in_vec(c1_c),
		.in_side({ay_s1, mid_s1}),
		.out_valid(nx_valid),
		.out_vec(ax),
		.out_side(nx_side)
	);

	assign ay_n = nx_side[6*UW-1:3*UW];

	// second cross product: ax x ay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x2_vld_s1 <= 1'b0;
		end else if (en) begin
			x2_vld_s1 <= nx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_p_s1[0] <= PW'($signed(ax[1])) * PW'($signed(ay_n[0]));
			x2_p_s1[1] <= PW'($signed(ax[0])) * PW'($signed(ay_n[1]));
			x2_p_s1[2] <= PW'($signed(ax[0])) * PW'($signed(ay_n[2]));
			x2_p_s1[3] <= PW'($signed(ax[2])) * PW'($signed(ay_n[0]));
			x2_p_s1[4] <= PW'($signed(ax[2])) * PW'($signed(ay_n[1]));
			x2_p_s1[5] <= PW'($signed(ax[1])) * PW'($signed(ay_n[2]));
			x2_ax_s1 <= ax;
			x2_ay_s1 <= ay_n;
			x2_mid_s1 <= nx_side[3*UW-1:0];
		end
	end

	always_comb begin
		c2_c[2] = x2_p_s1[0] - x2_p_s1[1];
		c2_c[1] = x2_p_s1[2] - x2_p_s1[3];
		c2_c[0] = x2_p_s1[4] - x2_p_s1[5];
	end

	ikpfb_norm #(.IW(PW), .SW(9 * UW), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_norm_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(x2_vld_s1),
		.in_vec(c2_c),
		.in_side({x2_ax_s1, x2_ay_s1, x2_mid_s1}),
		.out_valid(nz_valid),
		.out_vec(az),
		.out_side(nz_side)
	);

	assign frame_valid = nz_valid;

	always_comb begin
		frame.xaxis_x = nz_side[9*UW-1:8*UW];
		frame.xaxis_y = nz_side[8*UW-1:7*UW];
		frame.xaxis_z = nz_side[7*UW-1:6*UW];
		frame.yaxis_x = nz_side[6*UW-1:5*UW];
		frame.yaxis_y = nz_side[5*UW-1:4*UW];
		frame.yaxis_z = nz_side[4*UW-1:3*UW];
		frame.zaxis_x = az[2];
		frame.zaxis_y = az[1];
		frame.zaxis_z = az[0];
		frame.mid_x = nz_side[3*UW-1:2*UW];
		frame.mid_y = nz_side[2*UW-1:UW];
		frame.mid_z = nz_side[UW-1:0];
	end

`ifndef SYNTHESIS
	a_norm_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		nre_valid == nru_valid)
		else $error("direction normalizers out of step");

	a_y_zero_x_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame.yaxis_x == 0 && frame.yaxis_y == 0 && frame.yaxis_z == 0
		|-> frame.xaxis_x == 0 && frame.xaxis_y == 0 && frame.xaxis_z == 0)
		else $error("x axis not zero with zero y axis");

	a_x_zero_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame.xaxis_x == 0 && frame.xaxis_y == 0 && frame.xaxis_z == 0
		|-> frame.zaxis_x == 0 && frame.zaxis_y == 0 && frame.zaxis_z == 0)
		else $error("z axis not zero with zero x axis");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame.zaxis_x <= UNIT_ONE && frame.zaxis_x >= -UNIT_ONE
			&& frame.xaxis_y <= UNIT_ONE && frame.xaxis_y >= -UNIT_ONE)
		else $error("axis component beyond one");
`endif

endmodule

// ===== rtl/ikpfb_norm.sv =====
module ikpfb_norm #(
	parameter int IW = 33,
	parameter int SW = 1,
	parameter int UNIT_FRAC_BITS = ikpfb_pkg::UNIT_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2:0][IW-1:0] in_vec,
	input  logic [SW-1:0] in_side,
	output logic out_valid,
	output logic [2:0][ikpfb_pkg::UNIT_W-1:0] out_vec,
	output logic [SW-1:0] out_side
);

	localparam int NB = ikpfb_pkg::NORM_BITS;
	localparam int LZW = $clog2(IW);
	localparam int RB = ikpfb_pkg::ROOT_BITS;
	localparam int SQW = ikpfb_pkg::SQ_W;
	localparam int SPS = ikpfb_pkg::SQRT_STEPS_PER_STAGE;
	localparam int SQ_ST = (RB + SPS - 1) / SPS;
	localparam int QB = UNIT_FRAC_BITS + 1;
	localparam int DW = RB + UNIT_FRAC_BITS;
	localparam int DPS = ikpfb_pkg::DIV_STEPS_PER_STAGE;
	localparam int DV_ST = (QB + DPS - 1) / DPS;
	localparam int CW = SW + 4;
	localparam int UW = ikpfb_pkg::UNIT_W;

	// carry word: {side, zero, signs}
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][IW-1:0] mag_s1, mag_s2;
	logic [2:0] sgn_s1;
	logic [SW-1:0] side_s1;
	logic [LZW-1:0] lz_s2;
	logic [CW-1:0] car_s2, car_s3, car_s4;
	logic [2:0][NB-1:0] m_s3, m_s4;
	logic [2:0][2*NB-1:0] sq_s4;

	logic [SQW-1:0] rt_rem_s [SQ_ST];
	logic [RB-1:0] rt_val_s [SQ_ST+1];
	logic [2:0][NB-1:0] rt_m_s [SQ_ST+1];
	logic [CW-1:0] rt_car_s [SQ_ST+1];
	logic rt_vld_s [SQ_ST+1];

	logic [2:0][DW-1:0] dv_rem_s [DV_ST];
	logic [RB-1:0] dv_len_s [DV_ST];
	logic [2:0][QB-1:0] dv_q_s [DV_ST+1];
	logic [CW-1:0] dv_car_s [DV_ST+1];
	logic dv_vld_s [DV_ST+1];

	logic [IW-1:0] orw_c;
	logic [LZW-1:0] lz_c;
	logic [IW-1:0] shl_c [3];

	// valid chain of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			rt_vld_s[0] <= vld_s4;
		end
	end

	// magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sgn_s1[c] <= in_vec[c][IW-1];
				mag_s1[c] <= in_vec[c][IW-1] ? IW'(-in_vec[c]) : in_vec[c];
			end
			side_s1 <= in_side;
		end
	end

	// leading one of the largest magnitude
	always_comb begin
		orw_c = mag_s1[0] | mag_s1[1] | mag_s1[2];
		lz_c = '0;
		for (int i = 0; i < IW; i++) begin
			if (orw_c[i]) begin
				lz_c = LZW'(IW - 1 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lz_s2 <= lz_c;
			mag_s2 <= mag_s1;
			car_s2 <= {side_s1, (orw_c == '0), sgn_s1};
		end
	end

	// common shift so the largest lands in [2^30, 2^31)
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			shl_c[c] = mag_s2[c] << lz_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				m_s3[c] <= shl_c[c][IW-1 -: NB];
			end
			car_s3 <= car_s2;
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sq_s4[c] <= (2*NB)'(m_s3[c]) * (2*NB)'(m_s3[c]);
			end
			m_s4 <= m_s3;
			car_s4 <= car_s3;
		end
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0] <= SQW'(sq_s4[0]) + SQW'(sq_s4[1]) + SQW'(sq_s4[2]);
			rt_val_s[0] <= '0;
			rt_m_s[0] <= m_s4;
			rt_car_s[0] <= car_s4;
		end
	end

	// integer square root, two result bits per stage
	for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
		logic [SQW+1:0] rem_c;
		logic [SQW+1:0] t_c;
		logic [RB-1:0] val_c;

		always_comb begin
			rem_c = (SQW+2)'(rt_rem_s[g]);
			val_c = rt_val_s[g];
			t_c = '0;
			for (int k = 0; k < SPS; k++) begin
				if (g * SPS + k < RB) begin
					t_c = ((SQW+2)'(val_c) << (RB - g * SPS - k))
						+ ((SQW+2)'(1) << (2 * (RB - 1 - g * SPS - k)));
					if (rem_c >= t_c) begin
						rem_c = rem_c - t_c;
						val_c = val_c | (RB'(1) << (RB - 1 - g * SPS - k));
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[g+1] <= rt_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_val_s[g+1] <= val_c;
				rt_m_s[g+1] <= rt_m_s[g];
				rt_car_s[g+1] <= rt_car_s[g];
			end
		end

		if (g < SQ_ST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rt_rem_s[g+1] <= rem_c[SQW-1:0];
				end
			end
		end
	end

	// dividend with half the length added for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= rt_vld_s[SQ_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= (DW'(rt_m_s[SQ_ST][c]) << UNIT_FRAC_BITS)
					+ DW'(rt_val_s[SQ_ST] >> 1);
			end
			dv_len_s[0] <= rt_val_s[SQ_ST];
			dv_q_s[0] <= '0;
			dv_car_s[0] <= rt_car_s[SQ_ST];
		end
	end

	// restoring division, two quotient bits per stage
	for (genvar g = 0; g < DV_ST; g++) begin : g_div
		logic [2:0][DW-1:0] rem_c;
		logic [2:0][QB-1:0] q_c;
		logic [DW-1:0] dsh_c;

		always_comb begin
			rem_c = dv_rem_s[g];
			q_c = dv_q_s[g];
			dsh_c = '0;
			for (int k = 0; k < DPS; k++) begin
				if (g * DPS + k < QB) begin
					dsh_c = DW'(dv_len_s[g]) << (QB - 1 - g * DPS - k);
					for (int c = 0; c < 3; c++) begin
						if (rem_c[c] >= dsh_c) begin
							rem_c[c] = rem_c[c] - dsh_c;
							q_c[c] = q_c[c] | (QB'(1) << (QB - 1 - g * DPS - k));
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[g+1] <= dv_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_q_s[g+1] <= q_c;
				dv_car_s[g+1] <= dv_car_s[g];
			end
		end

		if (g < DV_ST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[g+1] <= rem_c;
					dv_len_s[g+1] <= dv_len_s[g];
				end
			end
		end
	end

	// signs back on, zero vector stays zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld_s[DV_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (dv_car_s[DV_ST][3]) begin
					out_vec[c] <= '0;
				end else if (dv_car_s[DV_ST][c]) begin
					out_vec[c] <= UW'(-UW'(dv_q_s[DV_ST][c]));
				end else begin
					out_vec[c] <= UW'(dv_q_s[DV_ST][c]);
				end
			end
			out_side <= dv_car_s[DV_ST][CW-1:4];
		end
	end

endmodule

// ===== test/tb_ik_plane_frame_builder.sv =====
`timescale 1ns / 1ps

module tb_ik_plane_frame_builder;

	localparam int LATENCY = 119;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic point_valid;
	logic point_stall;
	ikpfb_pkg::points_t points;
	logic frame_valid;
	logic frame_stall;
	ikpfb_pkg::frame_t frame;

	ikpfb_pkg::frame_t frames_due[$];
	int errors = 0;
	longint cycle = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	ik_plane_frame_builder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.points(points),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	task automatic unit_vector(input longint v[3], output longint u[3]);
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned q;
		int nb;
		mx = 0;
		sum = 0;
		nb = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
			return;
		end
		while (nb < 64 && (mx >> nb) != 0) nb++;
		for (int i = 0; i < 3; i++) begin
			if (nb > 31) m[i] >>= (nb - 31);
			else if (nb < 31) m[i] <<= (31 - nb);
			sum += m[i] * m[i];
		end
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << ikpfb_pkg::UNIT_FRAC_BITS) + (len >> 1)) / len;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endtask

	function automatic void cross3(input longint a[3], input longint b[3],
		output longint c[3]);
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	task automatic predict_frame(input ikpfb_pkg::points_t p, output ikpfb_pkg::frame_t f);
		longint r[3], e[3], t[3], re[3], ru[3], ure[3], uru[3];
		longint c[3], ax[3], ay[3], az[3], mid[3];
		r = '{longint'(p.root_x), longint'(p.root_y), longint'(p.root_z)};
		e = '{longint'(p.end_x), longint'(p.end_y), longint'(p.end_z)};
		t = '{longint'(p.up_x), longint'(p.up_y), longint'(p.up_z)};
		for (int i = 0; i < 3; i++) begin
			re[i] = e[i] - r[i];
			ru[i] = t[i] - r[i];
			mid[i] = (r[i] + e[i]) >>> 1;
		end
		unit_vector(re, ure);
		unit_vector(ru, uru);
		cross3(uru, ure, c);
		unit_vector(c, ax);
		for (int i = 0; i < 3; i++) ay[i] = -ure[i];
		cross3(ax, ay, c);
		unit_vector(c, az);
		f.xaxis_x = ax[0][31:0];
		f.xaxis_y = ax[1][31:0];
		f.xaxis_z = ax[2][31:0];
		f.yaxis_x = ay[0][31:0];
		f.yaxis_y = ay[1][31:0];
		f.yaxis_z = ay[2][31:0];
		f.zaxis_x = az[0][31:0];
		f.zaxis_y = az[1][31:0];
		f.zaxis_z = az[2][31:0];
		f.mid_x = mid[0][31:0];
		f.mid_y = mid[1][31:0];
		f.mid_z = mid[2][31:0];
	endtask

	task automatic send_points(input ikpfb_pkg::points_t p);
		ikpfb_pkg::frame_t f;
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			point_valid <= 1'b0;
			@(negedge clk);
		end
		point_valid <= 1'b1;
		points <= p;
		predict_frame(p, f);
		@(posedge clk);
		while (point_stall) @(posedge clk);
		frames_due.push_back(f);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		point_valid <= 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5, 0))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(4, 0) - 2;
			3: return {{12{$urandom_range(1, 0) == 1}}, 20'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic ikpfb_pkg::points_t random_points();
		ikpfb_pkg::points_t p;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		p.root_x = pick_coord();
		p.root_y = pick_coord();
		p.root_z = pick_coord();
		p.end_x = pick_coord();
		p.end_y = pick_coord();
		p.end_z = pick_coord();
		p.up_x = pick_coord();
		p.up_y = pick_coord();
		p.up_z = pick_coord();
		case ($urandom_range(9, 0))
			0: {p.end_x, p.end_y, p.end_z} = {p.root_x, p.root_y, p.root_z};
			1: {p.up_x, p.up_y, p.up_z} = {p.root_x, p.root_y, p.root_z};
			2: {p.up_x, p.up_y, p.up_z} = {p.end_x, p.end_y, p.end_z};
			default: ;
		endcase
		return p;
	endfunction

	task automatic test_directed();
		ikpfb_pkg::points_t p;
		logic [31:0] ext[4];
		ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_points('0);
		send_points({32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0});
		send_points({32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h20000, 32'h0});
		send_points({32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0});
		send_points({32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				p = {ext[i], ext[i], ext[i], ext[j], ext[j], ext[j],
					ext[(i + j) % 4], ext[j], ext[i]};
				send_points(p);
			end
		send_points({32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff});
		send_points({9{32'h55555555}});
		send_points({9{32'haaaaaaaa}});
		wait_drained();
	endtask

	task automatic test_random(input int count, input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) send_points(random_points());
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 3 * LATENCY;
		for (int i = 0; i < 300; i++) send_points(random_points());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		point_valid = 1'b0;
		points = '0;
		frame_stall = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(250, 0, 0);
		test_random(200, 67, 0);
		test_random(200, 0, 67);
		test_random(200, 12, 12);
		test_backpressure();
		repeat (LATENCY + 20) @(negedge clk);
		if (errors == 0 && frames_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			frame_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			frame_stall <= recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		ikpfb_pkg::frame_t want;
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && frame_valid && !frame_stall) begin
			if (frames_due.size() == 0) begin
				$display("%0t unexpected frame %h", $time, frame);
				errors++;
			end else begin
				want = frames_due.pop_front();
				if (frame !== want) begin
					$display("%0t frame mismatch expected %h actual %h", $time, want, frame);
					errors++;
				end
			end
		end
	end

endmodule
